// File: rtl/piot_pkg.sv
// Shared types and constants for the paced interval overrun tracker.
// Used by piot_div and paced_interval_overrun_tracker_unit; depends on nothing.
`timescale 1ns / 1ps

package piot_pkg;

  // Field widths
  localparam int TIME_BITS   = 40;
  localparam int COUNT_BITS  = 32;
  localparam int BUDGET_BITS = 16;
  localparam int TOTAL_BITS  = 64;

  // Saturating count adder and budget compare widths
  localparam int SUM_W = ((TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS) + 2;
  localparam int CMP_W = ((COUNT_BITS > BUDGET_BITS) ? COUNT_BITS : BUDGET_BITS) + 1;

  // Divider step counter
  localparam int DIV_CNT_W = $clog2(TIME_BITS + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TIME_BITS;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_NS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK_BUDGET = 1'd1;

  localparam logic [TIME_BITS-1:0] INTERVAL_RESET = TIME_BITS'(64'd1000000);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_PAUSE = 1'b1;

  // Divider request and response
  typedef struct packed {
    logic                 start;
    logic [TIME_BITS-1:0] dividend;
    logic [TIME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [TIME_BITS-1:0] quotient;
    logic [TIME_BITS-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/paced_interval_overrun_tracker_unit.sv
// Flow: a tick within the interval goes through the update and finish steps; an overrun
// tick with a nonzero interval first waits in the divide step; a pause beat takes the pause step.
// Throughput: one item at a time; input is ready again once the result sits in the
// output register, and a waiting result stalls only the finishing and pause steps.
// Reset (rst, synchronous): interval 1000000 ns, budget 0, count, flags and total zero.
// Depends on piot_pkg and piot_div.
`timescale 1ns / 1ps

module paced_interval_overrun_tracker_unit (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_we,
  input  logic [piot_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [piot_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input beat
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic [piot_pkg::TIME_BITS-1:0]      elapsed_ns,
  input  logic                                pause_value,
  // result beat
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [piot_pkg::TIME_BITS-1:0]      wait_ns,
  output logic [piot_pkg::TIME_BITS-1:0]      missed_intervals,
  output logic [piot_pkg::COUNT_BITS-1:0]     interval_count,
  output logic                                is_locked,
  output logic [piot_pkg::TOTAL_BITS-1:0]     total_elapsed_ns
);

  localparam int T = piot_pkg::TIME_BITS;
  localparam int C = piot_pkg::COUNT_BITS;
  localparam int B = piot_pkg::BUDGET_BITS;
  localparam int W = piot_pkg::TOTAL_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_UPDATE,
    S_FINISH,
    S_PAUSE
  } state_t;

  state_t state;

  // configuration registers
  logic [T-1:0] interval_ns;
  logic [B-1:0] lock_budget;

  // tracker state
  logic [C-1:0] count_reg;
  logic         locked_flag;
  logic         paused_flag;
  logic [W-1:0] total_time;
  logic [T-1:0] last_missed;

  // per-item working registers
  logic [T-1:0] el_q;
  logic         overrun_q;
  logic [T-1:0] missed_q;
  logic [T-1:0] rem_q;
  logic [T-1:0] wait_q;
  logic         pause_q;

  piot_pkg::div_req_t div_req;
  piot_pkg::div_rsp_t div_rsp;

  logic                   in_fire;
  logic                   slot_free;
  logic                   overrun_in;
  logic [piot_pkg::SUM_W-1:0] count_sum;
  logic [C-1:0]           count_sat;
  logic [T-1:0]           wait_raw;
  logic [piot_pkg::CMP_W-1:0] count_cmp;
  logic [piot_pkg::CMP_W-1:0] budget_cmp;
  logic                   grant;
  logic [T-1:0]           fin_wait;
  logic [W-1:0]           fin_total;
  logic                   fin_clear;
  logic [C-1:0]           fin_count;
  logic                   fin_locked;
  logic                   pz_clear;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid || out_ready;
  assign overrun_in = (elapsed_ns > interval_ns);

  // Start the divider only for an overrun with a nonzero interval
  always_comb begin
    div_req.start    = in_fire && (operation == piot_pkg::OP_TICK) && overrun_in
                       && (interval_ns != '0);
    div_req.dividend = elapsed_ns;
    div_req.divisor  = interval_ns;
  end

  piot_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Saturating count advance and remaining wait
  always_comb begin
    count_sum = piot_pkg::SUM_W'(count_reg) + piot_pkg::SUM_W'(missed_q)
                + piot_pkg::SUM_W'(1);
    count_sat = (count_sum > piot_pkg::SUM_W'(piot_pkg::COUNT_MAX))
                ? piot_pkg::COUNT_MAX : count_sum[C-1:0];
    if (overrun_q && (interval_ns == '0)) begin
      wait_raw = '0;
    end else begin
      wait_raw = interval_ns - (overrun_q ? rem_q : el_q);
    end
  end

  // Grant the wait and decide on unlocking
  always_comb begin
    count_cmp  = piot_pkg::CMP_W'(count_reg);
    budget_cmp = piot_pkg::CMP_W'(lock_budget);
    grant      = paused_flag || (count_cmp <= budget_cmp + piot_pkg::CMP_W'(1))
                 || (lock_budget == '0);
    fin_wait   = grant ? wait_q : '0;
    fin_total  = total_time + W'(fin_wait);
    fin_clear  = (lock_budget != '0) && !paused_flag && (count_cmp > budget_cmp);
    fin_count  = fin_clear ? '0 : count_reg;
    fin_locked = (lock_budget != '0) && !fin_clear;
    pz_clear   = !pause_q && (count_cmp >= budget_cmp);
  end

  // Hold configuration; writes are for the user to make only while idle, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_ns <= piot_pkg::INTERVAL_RESET;
      lock_budget <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        piot_pkg::CFG_INTERVAL_NS: interval_ns <= cfg_data[T-1:0];
        piot_pkg::CFG_LOCK_BUDGET: lock_budget <= cfg_data[B-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer, tracker state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      out_valid   <= 1'b0;
      count_reg   <= '0;
      locked_flag <= 1'b0;
      paused_flag <= 1'b0;
      total_time  <= '0;
      last_missed <= '0;
    end else begin
      // Drop the result once taken, unless a new one loads in the same cycle
      if (out_valid && out_ready && (state != S_FINISH) && (state != S_PAUSE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            el_q      <= elapsed_ns;
            overrun_q <= overrun_in;
            missed_q  <= overrun_in ? elapsed_ns : '0;
            pause_q   <= pause_value;
            if (operation == piot_pkg::OP_PAUSE) begin
              state <= S_PAUSE;
            end else if (div_req.start) begin
              state <= S_DIV;
            end else begin
              state <= S_UPDATE;
            end
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            missed_q <= div_rsp.quotient;
            rem_q    <= div_rsp.remainder;
            state    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          count_reg   <= count_sat;
          locked_flag <= 1'b1;
          last_missed <= missed_q;
          total_time  <= total_time + W'(el_q);
          wait_q      <= wait_raw;
          state       <= S_FINISH;
        end
        S_FINISH: begin
          if (slot_free) begin
            total_time       <= fin_total;
            count_reg        <= fin_count;
            locked_flag      <= fin_locked;
            out_valid        <= 1'b1;
            wait_ns          <= fin_wait;
            missed_intervals <= last_missed;
            interval_count   <= fin_count;
            is_locked        <= fin_locked;
            total_elapsed_ns <= fin_total;
            state            <= S_IDLE;
          end
        end
        S_PAUSE: begin
          if (slot_free) begin
            paused_flag      <= pause_q;
            out_valid        <= 1'b1;
            wait_ns          <= '0;
            missed_intervals <= last_missed;
            interval_count   <= pz_clear ? '0 : count_reg;
            is_locked        <= pz_clear ? 1'b0 : locked_flag;
            total_elapsed_ns <= total_time;
            if (pz_clear) begin
              count_reg   <= '0;
              locked_flag <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // One item in flight: an accepted beat closes the input until its result lands
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in flight");

  // The divider reports only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIV))
    else $error("divider finished outside the divide step");

  // The divider runs only during the divide step
  a_div_busy_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.busy |-> (state == S_DIV))
    else $error("divider busy outside the divide step");

  // A locked timer never shows a cleared count
  a_locked_count: assert property (@(posedge clk) disable iff (rst)
    locked_flag |-> (count_reg != '0))
    else $error("locked with a zero interval count");

endmodule

// File: rtl/piot_div.sv
// Iterative restoring divider: one quotient bit per cycle.
// Depends on piot_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module piot_div (
  input  logic              clk,
  input  logic              rst,
  input  piot_pkg::div_req_t req,
  output piot_pkg::div_rsp_t rsp
);

  localparam int T = piot_pkg::TIME_BITS;

  logic                           busy;
  logic                           done;
  logic [piot_pkg::DIV_CNT_W-1:0] cnt;
  logic [T-1:0]                   rem;
  logic [T-1:0]                   quo;
  logic [T-1:0]                   dvs;

  logic [T:0] shifted;
  logic [T:0] diff;
  logic       ge;

  // Shift in the next dividend bit and try one subtract
  always_comb begin
    shifted = {rem, quo[T-1]};
    diff    = shifted - {1'b0, dvs};
    ge      = (shifted >= {1'b0, dvs});
  end

  // Load on start, then advance one bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= piot_pkg::DIV_CNT_W'(T);
        rem  <= '0;
        quo  <= req.dividend;
        dvs  <= req.divisor;
      end else if (busy) begin
        rem <= ge ? diff[T-1:0] : shifted[T-1:0];
        quo <= {quo[T-2:0], ge};
        cnt <= cnt - piot_pkg::DIV_CNT_W'(1);
        if (cnt == piot_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule
